@@ hw/rtl/tpwp_pkg.sv @@
// ============================================================================
// tpwp_pkg
// Shared types and constants of the tape pulse waveform player: item opcodes,
// play phase codes, register indexes, reset values and the control bundles
// between the controller and the datapath.
// ============================================================================
package tpwp_pkg;

    // Item opcodes
    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_BYTE    = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;

    // Play phase, reported as is in the result item
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_PILOT = 3'd1,
        PH_SYNC  = 3'd2,
        PH_DATA  = 3'd3,
        PH_PAUSE = 3'd4
    } t_phase;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_PILOT_LEN   = 3'd0,
        CFG_PILOT_COUNT = 3'd1,
        CFG_SYNC_FIRST  = 3'd2,
        CFG_SYNC_SECOND = 3'd3,
        CFG_ZERO_LEN    = 3'd4,
        CFG_ONE_LEN     = 3'd5,
        CFG_FINAL_BITS  = 3'd6,
        CFG_PAUSE_MS    = 3'd7
    } t_cfg_idx;

    // Register reset values
    localparam logic [15:0] RST_PILOT_LEN   = 16'd2168;
    localparam logic [15:0] RST_PILOT_COUNT = 16'd8062;
    localparam logic [15:0] RST_SYNC_FIRST  = 16'd667;
    localparam logic [15:0] RST_SYNC_SECOND = 16'd735;
    localparam logic [15:0] RST_ZERO_LEN    = 16'd855;
    localparam logic [15:0] RST_ONE_LEN     = 16'd1710;
    localparam logic [3:0]  RST_FINAL_BITS  = 4'd8;
    localparam logic [15:0] RST_PAUSE_MS    = 16'd1000;

    // Signed T-state balance; it stays within one 16-bit length of zero on either side
    localparam int unsigned DEBT_W      = 18;
    localparam int unsigned DATA_BITS_W = 28;

    // Controller to datapath commands
    typedef struct packed {
        logic apply;     // apply the accepted item
        logic step;      // run one engine step
        logic load_out;  // capture the status into the result register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic busy;      // engine has work at the current time balance
    } t_status;

endpackage

@@ hw/rtl/tpwp_ctrl.sv @@
// ============================================================================
// tpwp_ctrl
// Controller: takes one item, steps the pulse engine until it settles and
// hands the status to the result register.
// ============================================================================
module tpwp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  tpwp_pkg::t_status i_status,
    output tpwp_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_ctrl_state;

    t_ctrl_state r_state, n_state;
    logic        r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    // Sequence: apply item, step engine, load result when the slot is free
    always_comb begin
        n_state         = r_state;
        o_cmd.apply     = 1'b0;
        o_cmd.step      = 1'b0;
        o_cmd.load_out  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.apply = 1'b1;
                    n_state     = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_status.busy) begin
                    o_cmd.step = 1'b1;
                end else if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold the result until taken
    always_comb begin
        n_out_valid = (r_out_valid && !i_out_ready) || o_cmd.load_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ hw/rtl/tpwp_datapath.sv @@
// ============================================================================
// tpwp_datapath
// Datapath: configuration registers, block play state, one-step pulse engine
// and the result register.
// ============================================================================
module tpwp_datapath #(
    parameter int unsigned PAUSE_CHUNK = 3500
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tpwp_pkg::t_cmd    i_cmd,
    output tpwp_pkg::t_status o_status,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_addr,
    input  logic [15:0]       i_cfg_wdata,
    input  logic [1:0]        i_opcode,
    input  logic [7:0]        i_data_byte,
    input  logic [23:0]       i_byte_total,
    input  logic [15:0]       i_elapsed_tstates,
    output logic              o_ear_level,
    output logic              o_need_byte,
    output logic [2:0]        o_phase,
    output logic              o_playing
);

    localparam int unsigned ChunkW = $clog2(PAUSE_CHUNK + 1);
    localparam int unsigned PauseW = 16 + ChunkW;
    localparam int unsigned DW     = tpwp_pkg::DEBT_W;
    localparam int unsigned BW     = tpwp_pkg::DATA_BITS_W;

    // Configuration registers
    logic [15:0] r_pilot_len, r_pilot_count, r_sync_first, r_sync_second;
    logic [15:0] r_zero_len, r_one_len, r_pause_ms;
    logic [3:0]  r_final_bits;

    // Play state
    logic signed [DW-1:0] r_debt, n_debt;
    tpwp_pkg::t_phase     r_phase, n_phase;
    logic                 r_level, n_level;
    logic [15:0]          r_pulses, n_pulses;
    logic                 r_sync_step, n_sync_step;
    logic                 r_half, n_half;
    logic [3:0]           r_bits, n_bits;
    logic [7:0]           r_shift, n_shift;
    logic                 r_held, n_held;
    logic [BW-1:0]        r_bits_left, n_bits_left;
    logic [PauseW-1:0]    r_pause_left, n_pause_left;
    logic                 r_pause_begun, n_pause_begun;

    // Result register
    logic       r_out_level, r_out_need, r_out_playing;
    logic [2:0] r_out_phase;

    logic              debt_le0, awaiting, pilot_on, sync_on;
    logic [3:0]        final_bits;
    logic [BW-1:0]     start_bits;
    logic [PauseW-1:0] chunk;
    logic [15:0]       bit_pulse_len;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pilot_len   <= tpwp_pkg::RST_PILOT_LEN;
            r_pilot_count <= tpwp_pkg::RST_PILOT_COUNT;
            r_sync_first  <= tpwp_pkg::RST_SYNC_FIRST;
            r_sync_second <= tpwp_pkg::RST_SYNC_SECOND;
            r_zero_len    <= tpwp_pkg::RST_ZERO_LEN;
            r_one_len     <= tpwp_pkg::RST_ONE_LEN;
            r_final_bits  <= tpwp_pkg::RST_FINAL_BITS;
            r_pause_ms    <= tpwp_pkg::RST_PAUSE_MS;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                tpwp_pkg::CFG_PILOT_LEN:   r_pilot_len   <= i_cfg_wdata;
                tpwp_pkg::CFG_PILOT_COUNT: r_pilot_count <= i_cfg_wdata;
                tpwp_pkg::CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_wdata;
                tpwp_pkg::CFG_SYNC_SECOND: r_sync_second <= i_cfg_wdata;
                tpwp_pkg::CFG_ZERO_LEN:    r_zero_len    <= i_cfg_wdata;
                tpwp_pkg::CFG_ONE_LEN:     r_one_len     <= i_cfg_wdata;
                tpwp_pkg::CFG_FINAL_BITS:  r_final_bits  <= i_cfg_wdata[3:0];
                tpwp_pkg::CFG_PAUSE_MS:    r_pause_ms    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Engine status
    assign debt_le0 = r_debt[DW-1] || (r_debt == '0);
    assign awaiting = (r_phase == tpwp_pkg::PH_DATA) && (r_bits_left != '0) && !r_held;
    assign o_status.busy = (r_phase != tpwp_pkg::PH_IDLE) && debt_le0 && !awaiting;

    // Block setup values
    assign pilot_on   = (r_pilot_len != '0) && (r_pilot_count != '0);
    assign sync_on    = (r_sync_first != '0) && (r_sync_second != '0);
    assign final_bits = ((r_final_bits == '0) || (r_final_bits > 4'd8)) ? 4'd8 : r_final_bits;
    assign start_bits = (i_byte_total == '0) ? '0 :
                        ({1'b0, i_byte_total, 3'b000} - BW'(8) + BW'(final_bits));

    // Pause chunk and data pulse length
    assign chunk         = (r_pause_left > PauseW'(PAUSE_CHUNK)) ? PauseW'(PAUSE_CHUNK)
                                                                 : r_pause_left;
    assign bit_pulse_len = r_shift[7] ? r_one_len : r_zero_len;

    // Apply items and advance the engine one step at a time
    always_comb begin
        n_debt        = r_debt;
        n_phase       = r_phase;
        n_level       = r_level;
        n_pulses      = r_pulses;
        n_sync_step   = r_sync_step;
        n_half        = r_half;
        n_bits        = r_bits;
        n_shift       = r_shift;
        n_held        = r_held;
        n_bits_left   = r_bits_left;
        n_pause_left  = r_pause_left;
        n_pause_begun = r_pause_begun;
        if (i_cmd.apply) begin
            case (i_opcode)
                tpwp_pkg::OP_START: begin
                    n_bits_left   = start_bits;
                    n_pause_left  = PauseW'(r_pause_ms) * PauseW'(PAUSE_CHUNK);
                    n_debt        = '0;
                    n_sync_step   = 1'b0;
                    n_half        = 1'b0;
                    n_bits        = '0;
                    n_held        = 1'b0;
                    n_pause_begun = 1'b0;
                    if (pilot_on) begin
                        n_phase  = tpwp_pkg::PH_PILOT;
                        n_pulses = r_pilot_count;
                    end else if (sync_on) begin
                        n_phase  = tpwp_pkg::PH_SYNC;
                        n_pulses = 16'd2;
                    end else begin
                        n_phase  = tpwp_pkg::PH_DATA;
                        n_pulses = '0;
                    end
                end
                tpwp_pkg::OP_BYTE: begin
                    if ((r_phase != tpwp_pkg::PH_IDLE) && (r_bits_left != '0) && !r_held) begin
                        n_shift = i_data_byte;
                        n_held  = 1'b1;
                        n_bits  = 4'd8;
                        n_half  = 1'b0;
                    end
                end
                tpwp_pkg::OP_ADVANCE: begin
                    if ((r_phase != tpwp_pkg::PH_IDLE) && !(awaiting && debt_le0)) begin
                        n_debt = r_debt - $signed({2'b00, i_elapsed_tstates});
                    end
                end
                default: ;
            endcase
        end else if (i_cmd.step) begin
            case (r_phase)
                tpwp_pkg::PH_PILOT: begin
                    if (r_pulses == '0) begin
                        if (sync_on) begin
                            n_phase     = tpwp_pkg::PH_SYNC;
                            n_pulses    = 16'd2;
                            n_sync_step = 1'b0;
                        end else begin
                            n_phase = tpwp_pkg::PH_DATA;
                        end
                    end else begin
                        n_level  = !r_level;
                        n_debt   = r_debt + $signed({2'b00, r_pilot_len});
                        n_pulses = r_pulses - 16'd1;
                    end
                end
                tpwp_pkg::PH_SYNC: begin
                    if (r_pulses == '0) begin
                        n_phase = tpwp_pkg::PH_DATA;
                    end else begin
                        n_level     = !r_level;
                        n_debt      = r_debt + $signed({2'b00,
                                      (r_sync_step ? r_sync_second : r_sync_first)});
                        n_sync_step = 1'b1;
                        n_pulses    = r_pulses - 16'd1;
                    end
                end
                tpwp_pkg::PH_DATA: begin
                    if (r_bits_left == '0) begin
                        n_phase = tpwp_pkg::PH_PAUSE;
                    end else begin
                        n_level = !r_level;
                        n_debt  = r_debt + $signed({2'b00, bit_pulse_len});
                        if (!r_half) begin
                            n_half = 1'b1;
                        end else begin
                            // second half done: drop the bit
                            n_half      = 1'b0;
                            n_bits      = r_bits - 4'd1;
                            n_bits_left = r_bits_left - BW'(1);
                            n_shift     = {r_shift[6:0], 1'b0};
                            if ((r_bits == 4'd1) || (r_bits_left == BW'(1))) begin
                                n_held = 1'b0;
                                n_bits = '0;
                            end
                        end
                    end
                end
                tpwp_pkg::PH_PAUSE: begin
                    if (r_pause_left == '0) begin
                        n_phase = tpwp_pkg::PH_IDLE;
                    end else begin
                        n_debt       = r_debt + $signed({2'b00, 16'(chunk)});
                        n_pause_left = r_pause_left - chunk;
                        if (r_pause_begun) begin
                            n_level = 1'b0;
                        end else begin
                            n_pause_begun = 1'b1;
                            n_level       = !r_level;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debt        <= '0;
            r_phase       <= tpwp_pkg::PH_IDLE;
            r_level       <= 1'b0;
            r_pulses      <= '0;
            r_sync_step   <= 1'b0;
            r_half        <= 1'b0;
            r_bits        <= '0;
            r_held        <= 1'b0;
            r_bits_left   <= '0;
            r_pause_left  <= '0;
            r_pause_begun <= 1'b0;
        end else begin
            r_debt        <= n_debt;
            r_phase       <= n_phase;
            r_level       <= n_level;
            r_pulses      <= n_pulses;
            r_sync_step   <= n_sync_step;
            r_half        <= n_half;
            r_bits        <= n_bits;
            r_held        <= n_held;
            r_bits_left   <= n_bits_left;
            r_pause_left  <= n_pause_left;
            r_pause_begun <= n_pause_begun;
        end
    end

    // Shift byte holds data only once a byte has been supplied
    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
    end

    // Capture the settled status as the result item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_level   <= r_level;
            r_out_need    <= awaiting;
            r_out_phase   <= r_phase;
            r_out_playing <= (r_phase != tpwp_pkg::PH_IDLE);
        end
    end

    assign o_ear_level = r_out_level;
    assign o_need_byte = r_out_need;
    assign o_phase     = r_out_phase;
    assign o_playing   = r_out_playing;

endmodule

@@ hw/rtl/tape_pulse_waveform_player.sv @@
// ============================================================================
// tape_pulse_waveform_player
// Top level: tape signal level generator for one standard or custom block.
// ============================================================================
// An item is applied, then the pulse engine makes one step for every pulse edge,
// pause chunk or phase change that it sets off, one such step per cycle, and
// the status is then loaded into the result register; a byte played at zero
// bit lengths sets off all of its edges in one run of steps. Each item returns one
// result item with the status after it; the result sits in an output
// register, so the next item is taken while it waits, but that item's result
// is held back until the register is read. Registers are written through the
// plain write port; the user must write them only while no item is in flight,
// as the block itself does not enforce it.
module tape_pulse_waveform_player #(
    parameter int unsigned PAUSE_CHUNK = 3500
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_data_byte,
    input  logic [23:0] i_byte_total,
    input  logic [15:0] i_elapsed_tstates,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_ear_level,
    output logic        o_need_byte,
    output logic [2:0]  o_phase,
    output logic        o_playing
);

    tpwp_pkg::t_cmd    cmd;
    tpwp_pkg::t_status status;

    // Sequence items
    tpwp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Play state and pulse engine
    tpwp_datapath #(
        .PAUSE_CHUNK (PAUSE_CHUNK)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_opcode          (i_opcode),
        .i_data_byte       (i_data_byte),
        .i_byte_total      (i_byte_total),
        .i_elapsed_tstates (i_elapsed_tstates),
        .o_ear_level       (o_ear_level),
        .o_need_byte       (o_need_byte),
        .o_phase           (o_phase),
        .o_playing         (o_playing)
    );

    // A byte is only awaited while the data phase plays
    a_need_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_need_byte || (o_playing && (o_phase == tpwp_pkg::PH_DATA))))
        else $error("need_byte reported outside the data phase");

    // Playing flag agrees with the phase
    a_playing_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_playing == (o_phase != tpwp_pkg::PH_IDLE)))
        else $error("playing flag disagrees with phase");

    // The engine never steps or loads the result while a new item may enter
    a_no_step_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.step || cmd.load_out) |-> !o_in_ready)
        else $error("engine active while input is open");

endmodule
